// ===== src/drle_pkg.sv =====
// ----------------------------------------------------------------------------
// drle_pkg
// Shared constants, codes and character helpers for the trouble-code list engine.
// ----------------------------------------------------------------------------
package drle_pkg;

	// Default list capacity
	localparam int DefMaxEntries = 16;
	localparam int NumLists      = 3;

	// Operation codes
	localparam logic [1:0] OP_BYTE  = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// List selectors
	localparam logic [1:0] LIST_CURRENT   = 2'd0;
	localparam logic [1:0] LIST_PENDING   = 2'd1;
	localparam logic [1:0] LIST_PERMANENT = 2'd2;
	localparam logic [1:0] LIST_STORED    = 2'd3;

	// Result kinds
	localparam logic [1:0] KIND_NONE     = 2'd0;
	localparam logic [1:0] KIND_STORED   = 2'd1;
	localparam logic [1:0] KIND_READ     = 2'd2;
	localparam logic [1:0] KIND_READ_ERR = 2'd3;

	// System classes
	localparam logic [1:0] CLS_POWERTRAIN = 2'd0;
	localparam logic [1:0] CLS_CHASSIS    = 2'd1;
	localparam logic [1:0] CLS_BODY       = 2'd2;

	// ASCII constants
	localparam logic [7:0] ASCII_ZERO   = 8'h30;
	localparam logic [7:0] ASCII_A      = 8'h41;
	localparam logic [7:0] ASCII_P      = 8'h50;
	localparam logic [7:0] ASCII_C      = 8'h43;
	localparam logic [7:0] ASCII_B      = 8'h42;
	localparam logic [7:0] ASCII_U      = 8'h55;
	localparam logic [3:0] NIB_TEN      = 4'd10;

	// Uppercase hex character of one nibble
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] ch;
		if (nib < NIB_TEN) begin
			ch = ASCII_ZERO + {4'h0, nib};
		end else begin
			ch = ASCII_A + {4'h0, nib - NIB_TEN};
		end
		return ch;
	endfunction

	// System letter of a class
	function automatic logic [7:0] sys_letter(input logic [1:0] cls);
		logic [7:0] ch;
		case (cls)
			CLS_POWERTRAIN: ch = ASCII_P;
			CLS_CHASSIS:    ch = ASCII_C;
			CLS_BODY:       ch = ASCII_B;
			default:        ch = ASCII_U;
		endcase
		return ch;
	endfunction

endpackage

// ===== src/dtc_response_list_engine.sv =====
// ----------------------------------------------------------------------------
// dtc_response_list_engine
// Pairs trouble-code response bytes into 16-bit codes, keeps them in three
// lists (current, pending, permanent) with a timestamp, and serves reads.
// Every transaction on the slave side yields exactly one result transaction.
// The block takes one transaction per cycle unless the output stalls; its
// result passes the store stage, for the entry store access, and is then
// decoded from there into the output register. The entry store is a single
// port memory of 3 x MAX_ENTRIES words of code and time, written when a code
// is kept and read for a read operation; list counts and byte pairing sit in
// flip-flops. A stalled output holds one result while one more waits in the
// store stage, and the slave side then stalls. No clearing pass is needed:
// only slots below a list count are ever read.
// ----------------------------------------------------------------------------
module dtc_response_list_engine #(
	parameter int MAX_ENTRIES = drle_pkg::DefMaxEntries
) (
	input  logic         clk,
	input  logic         arst_n,
	// slave side
	input  logic         s_tvalid,
	output logic         s_tready,
	// tdata: data_byte[7:0], read_index[11:8], now_ms[43:12], zero pad
	input  logic [47:0]  s_tdata,
	// tuser: op[1:0], list_type[3:2], start_of_response[4]
	input  logic [4:0]   s_tuser,
	// master side
	output logic         m_tvalid,
	input  logic         m_tready,
	// tdata: trouble_code[15:0], system_class[17:16], system_letter[25:18],
	// subsystem_digit[33:26], hex_char_high[41:34], hex_char_mid[49:42],
	// hex_char_low[57:50], slot_index[61:58], entry_time[93:62],
	// list_count[98:94], total_count[104:99], zero pad
	output logic [111:0] m_tdata,
	// tuser: result_kind[1:0]
	output logic [1:0]   m_tuser
);
	import drle_pkg::*;

	localparam int Depth = NumLists * MAX_ENTRIES;
	localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW    = $clog2(MAX_ENTRIES + 1);
	localparam int IW    = (CW > 4) ? CW : 4;
	localparam int TW    = CW + 2;

	// Input fields
	logic [1:0]  op;
	logic [1:0]  list_type;
	logic        start_of_response;
	logic [7:0]  data_byte;
	logic [3:0]  read_index;
	logic [31:0] now_ms;
	logic [1:0]  lst;
	logic        in_acc;

	assign op                = s_tuser[1:0];
	assign list_type         = s_tuser[3:2];
	assign start_of_response = s_tuser[4];
	assign data_byte         = s_tdata[7:0];
	assign read_index        = s_tdata[11:8];
	assign now_ms            = s_tdata[43:12];
	assign lst               = (list_type == LIST_STORED) ? LIST_CURRENT : list_type;
	assign in_acc            = s_tvalid && s_tready;

	// Architectural state
	logic [CW-1:0] count_q [NumLists];
	logic [7:0]    held_q;
	logic          phase_q;

	// Entry store: code in the upper 16 bits, time in the lower 32
	logic [47:0] mem [Depth];
	logic [47:0] rd_q;

	// Next-state and per-transaction values
	logic [CW-1:0] cnt_d [NumLists];
	logic [CW-1:0] cnt_sel;
	logic [7:0]    held_d;
	logic          phase_d;
	logic          phase_eff;
	logic [15:0]   pair;
	logic [1:0]    kind;
	logic          wr_en;
	logic          rd_en;
	logic [IW-1:0] slot;
	logic [15:0]   code;
	logic [31:0]   etime;
	logic [AW-1:0] addr;
	logic [TW-1:0] total_d;

	assign pair = {held_q, data_byte};

	// Decode the operation against the current counts and pairing
	always_comb begin
		cnt_d     = count_q;
		held_d    = held_q;
		phase_d   = phase_q;
		cnt_sel   = count_q[lst];
		phase_eff = phase_q;
		kind      = KIND_NONE;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		slot      = '0;
		code      = '0;
		etime     = '0;
		case (op)
			OP_BYTE: begin
				if (start_of_response) begin
					cnt_sel   = '0;
					phase_eff = 1'b0;
				end
				cnt_d[lst] = cnt_sel;
				if (!phase_eff) begin
					held_d  = data_byte;
					phase_d = 1'b1;
				end else begin
					phase_d = 1'b0;
					if (pair != 16'h0000 && cnt_sel < CW'(MAX_ENTRIES)) begin
						wr_en      = 1'b1;
						kind       = KIND_STORED;
						slot       = IW'(cnt_sel);
						code       = pair;
						etime      = now_ms;
						cnt_d[lst] = CW'(cnt_sel + 1'b1);
					end
				end
			end
			OP_CLEAR: begin
				cnt_d[LIST_CURRENT] = '0;
				cnt_d[LIST_PENDING] = '0;
			end
			OP_READ: begin
				if (IW'(read_index) < IW'(count_q[lst]) &&
				    IW'(read_index) < IW'(MAX_ENTRIES)) begin
					rd_en = 1'b1;
					kind  = KIND_READ;
					slot  = IW'(read_index);
				end else begin
					kind = KIND_READ_ERR;
				end
			end
			default: begin
			end
		endcase
	end

	assign addr    = AW'(32'(lst) * MAX_ENTRIES + 32'(slot));
	assign total_d = TW'(cnt_d[LIST_CURRENT]) + TW'(cnt_d[LIST_PENDING]) +
	                 TW'(cnt_d[LIST_PERMANENT]);

	// Commit counts and pairing on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumLists; i++) begin
				count_q[i] <= '0;
			end
			held_q  <= '0;
			phase_q <= 1'b0;
		end else if (in_acc) begin
			count_q <= cnt_d;
			held_q  <= held_d;
			phase_q <= phase_d;
		end
	end

	// Access the entry store: one write or one read per transaction
	always_ff @(posedge clk) begin
		if (in_acc && wr_en) begin
			mem[addr] <= {code, etime};
		end
		if (in_acc && rd_en) begin
			rd_q <= mem[addr];
		end
	end

	// Store stage
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic        rd_s1;
	logic [15:0] code_s1;
	logic [31:0] time_s1;
	logic [3:0]  slot_s1;
	logic [4:0]  lcnt_s1;
	logic [5:0]  tcnt_s1;

	// Output register
	logic         m_valid_q;
	logic [111:0] m_data_q;
	logic [1:0]   m_user_q;
	logic         out_free;
	logic         out_load;

	assign out_free = !m_valid_q || m_tready;
	assign out_load = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// Advance the store stage and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Hold the transaction's fields while its store access completes
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1 <= kind;
			rd_s1   <= rd_en;
			code_s1 <= code;
			time_s1 <= etime;
			slot_s1 <= slot[3:0];
			lcnt_s1 <= 5'(cnt_d[lst]);
			tcnt_s1 <= 6'(total_d);
		end
	end

	// Decode the entry into characters
	logic        has_entry;
	logic [15:0] fin_code;
	logic [31:0] fin_time;
	logic [1:0]  cls;
	logic [7:0]  letter;
	logic [7:0]  digit;
	logic [7:0]  hx_hi;
	logic [7:0]  hx_mid;
	logic [7:0]  hx_lo;

	assign has_entry = rd_s1 || (kind_s1 == KIND_STORED);
	assign fin_code  = rd_s1 ? rd_q[47:32] : code_s1;
	assign fin_time  = rd_s1 ? rd_q[31:0] : time_s1;
	assign cls       = has_entry ? fin_code[15:14] : 2'b00;
	assign letter    = has_entry ? sys_letter(fin_code[15:14]) : 8'h00;
	assign digit     = has_entry ? (ASCII_ZERO + {6'h00, fin_code[13:12]}) : 8'h00;
	assign hx_hi     = has_entry ? hex_char(fin_code[11:8]) : 8'h00;
	assign hx_mid    = has_entry ? hex_char(fin_code[7:4]) : 8'h00;
	assign hx_lo     = has_entry ? hex_char(fin_code[3:0]) : 8'h00;

	// Load the output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_user_q <= kind_s1;
			m_data_q <= {7'h00, tcnt_s1, lcnt_s1, fin_time, slot_s1, hx_lo, hx_mid,
			             hx_hi, digit, letter, cls, fin_code};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;

	// A list never holds more than its capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[LIST_CURRENT] <= CW'(MAX_ENTRIES) &&
		count_q[LIST_PENDING] <= CW'(MAX_ENTRIES) &&
		count_q[LIST_PERMANENT] <= CW'(MAX_ENTRIES))
		else $error("list count beyond capacity");

	// A start byte is always taken as the high byte of a pair
	a_start_phase: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && op == OP_BYTE && start_of_response |=> phase_q)
		else $error("start byte not held as high byte");

	// A kept code is never zero
	a_stored_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_STORED |-> m_tdata[15:0] != 16'h0000)
		else $error("zero code reported as stored");

	// A waiting store-stage transaction is not lost while the output stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(kind_s1))
		else $error("store stage dropped a transaction");

endmodule

// ===== tb/sv/dtc_response_list_engine_tb.sv =====
// ----------------------------------------------------------------------------
// dtc_response_list_engine_tb
// Drives trouble-code response bytes, clears and reads into the list engine
// and checks every result transaction against a local model of the three
// lists: a directed table first, then randomised responses, reads and noise,
// with random gaps on the slave side and random stalls on the master side.
// ----------------------------------------------------------------------------
module dtc_response_list_engine_tb;
	import drle_pkg::*;

	localparam int         MaxEntries   = DefMaxEntries;
	localparam int         RandomItems  = 1350;
	localparam int         CycleLimit   = 200000;
	localparam int         DrainCycles  = 20;
	localparam int         IdlePercent  = 16;
	localparam int         QuietFrom    = 1500;
	localparam int         QuietTo      = 2100;
	localparam logic [1:0] OP_NOP       = 2'd3;
	localparam logic [1:0] CLS_NETWORK  = 2'd3;
	localparam string      HEX_DIGITS   = "0123456789ABCDEF";
	localparam string      SYS_LETTERS  = "PCBU";

	typedef struct packed {
		logic [1:0]  op;
		logic [1:0]  lst;
		logic        start;
		logic [7:0]  data;
		logic [3:0]  idx;
		logic [31:0] ts;
	} dtc_req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] code;
		logic [1:0]  cls;
		logic [7:0]  letter;
		logic [7:0]  digit;
		logic [7:0]  hex_hi;
		logic [7:0]  hex_mid;
		logic [7:0]  hex_lo;
		logic [3:0]  slot;
		logic [31:0] stamp;
		logic [4:0]  lcount;
		logic [5:0]  tcount;
	} dtc_res_t;

	typedef struct packed {
		dtc_req_t req;
		logic     typed;
		dtc_res_t res;
	} dtc_row_t;

	localparam dtc_res_t NO_CHECK = '0;

	// Directed rows; a typed result replaces the model's where it is obvious
	localparam dtc_row_t DIRECTED [24] = '{
		'{'{OP_READ, LIST_CURRENT, 1'b0, 8'h00, 4'd0, 32'd0}, 1'b1,
			'{KIND_READ_ERR, 16'h0, 2'd0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 4'd0, 32'd0,
			5'd0, 6'd0}},
		'{'{OP_NOP, LIST_PENDING, 1'b1, 8'hFF, 4'd15, 32'hFFFFFFFF}, 1'b1,
			'{KIND_NONE, 16'h0, 2'd0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 4'd0, 32'd0,
			5'd0, 6'd0}},
		'{'{OP_BYTE, LIST_CURRENT, 1'b1, 8'hFF, 4'd0, 32'd0}, 1'b1,
			'{KIND_NONE, 16'h0, 2'd0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 4'd0, 32'd0,
			5'd0, 6'd0}},
		'{'{OP_BYTE, LIST_CURRENT, 1'b0, 8'hFF, 4'd0, 32'hFFFFFFFF}, 1'b1,
			'{KIND_STORED, 16'hFFFF, CLS_NETWORK, ASCII_U, "3", "F", "F", "F", 4'd0,
			32'hFFFFFFFF, 5'd1, 6'd1}},
		'{'{OP_BYTE, LIST_PENDING, 1'b1, 8'h00, 4'd0, 32'd0}, 1'b1,
			'{KIND_NONE, 16'h0, 2'd0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 4'd0, 32'd0,
			5'd0, 6'd1}},
		'{'{OP_BYTE, LIST_PENDING, 1'b0, 8'h00, 4'd0, 32'd7}, 1'b1,
			'{KIND_NONE, 16'h0, 2'd0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 4'd0, 32'd0,
			5'd0, 6'd1}},
		'{'{OP_BYTE, LIST_PENDING, 1'b0, 8'h01, 4'd0, 32'd1}, 1'b0, NO_CHECK},
		'{'{OP_BYTE, LIST_PENDING, 1'b0, 8'h23, 4'd0, 32'd2}, 1'b0, NO_CHECK},
		// high byte on one list, low byte on another
		'{'{OP_BYTE, LIST_PERMANENT, 1'b0, 8'h4A, 4'd0, 32'd0}, 1'b0, NO_CHECK},
		'{'{OP_BYTE, LIST_CURRENT, 1'b0, 8'hBC, 4'd0, 32'd3}, 1'b0, NO_CHECK},
		'{'{OP_READ, LIST_STORED, 1'b0, 8'h00, 4'd1, 32'd0}, 1'b0, NO_CHECK},
		'{'{OP_BYTE, LIST_STORED, 1'b1, 8'h80, 4'd0, 32'd0}, 1'b0, NO_CHECK},
		'{'{OP_BYTE, LIST_STORED, 1'b0, 8'h00, 4'd0, 32'd4}, 1'b0, NO_CHECK},
		// trailing odd byte, then overwritten by the next start
		'{'{OP_BYTE, LIST_PERMANENT, 1'b1, 8'h12, 4'd0, 32'd0}, 1'b0, NO_CHECK},
		'{'{OP_READ, LIST_PERMANENT, 1'b0, 8'h00, 4'd0, 32'd0}, 1'b0, NO_CHECK},
		'{'{OP_BYTE, LIST_PERMANENT, 1'b1, 8'hC3, 4'd0, 32'd0}, 1'b0, NO_CHECK},
		'{'{OP_BYTE, LIST_PERMANENT, 1'b0, 8'h45, 4'd0, 32'd5}, 1'b0, NO_CHECK},
		'{'{OP_CLEAR, LIST_CURRENT, 1'b0, 8'h00, 4'd0, 32'd0}, 1'b0, NO_CHECK},
		'{'{OP_READ, LIST_PENDING, 1'b0, 8'h00, 4'd0, 32'd0}, 1'b0, NO_CHECK},
		'{'{OP_READ, LIST_PERMANENT, 1'b0, 8'h00, 4'd0, 32'd0}, 1'b0, NO_CHECK},
		'{'{OP_READ, LIST_PERMANENT, 1'b0, 8'h00, 4'd15, 32'd0}, 1'b0, NO_CHECK},
		'{'{OP_BYTE, LIST_CURRENT, 1'b0, 8'hA5, 4'd0, 32'd0}, 1'b0, NO_CHECK},
		'{'{OP_BYTE, LIST_CURRENT, 1'b0, 8'h5A, 4'd0, 32'hAAAAAAAA}, 1'b0, NO_CHECK},
		'{'{OP_READ, LIST_CURRENT, 1'b0, 8'h00, 4'd0, 32'h55555555}, 1'b0, NO_CHECK}
	};

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [47:0]  s_tdata  = '0;
	logic [4:0]   s_tuser  = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;
	logic [1:0]   m_tuser;

	// Model state of the lists and byte pairing
	logic [15:0]  list_code [3][MaxEntries];
	logic [31:0]  list_stamp [3][MaxEntries];
	logic [4:0]   list_fill [3] = '{5'd0, 5'd0, 5'd0};
	logic [7:0]   held_byte  = 8'h00;
	logic         low_next   = 1'b0;

	dtc_row_t     request_queue [$];
	dtc_res_t     results_due [$];
	dtc_row_t     in_flight;
	int           cycle_count  = 0;
	int           error_count  = 0;
	int           sent_count   = 0;
	int           result_count = 0;
	int           kind_seen [4] = '{0, 0, 0, 0};

	dtc_response_list_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// Spell out a code as letter, digit and three hex characters
	function automatic dtc_res_t spell_code(input logic [1:0] kind, input logic [15:0] code,
			input logic [3:0] slot, input logic [31:0] stamp);
		dtc_res_t r;
		r         = '0;
		r.kind    = kind;
		r.code    = code;
		r.cls     = code[15:14];
		r.letter  = SYS_LETTERS[code[15:14]];
		r.digit   = HEX_DIGITS[{2'b00, code[13:12]}];
		r.hex_hi  = HEX_DIGITS[code[11:8]];
		r.hex_mid = HEX_DIGITS[code[7:4]];
		r.hex_lo  = HEX_DIGITS[code[3:0]];
		r.slot    = slot;
		r.stamp   = stamp;
		return r;
	endfunction

	// Apply one transaction to the list model and return its result
	function automatic dtc_res_t step_code_lists(input dtc_req_t q);
		dtc_res_t    r;
		int          l;
		logic [15:0] code;
		r = '0;
		l = (q.lst == LIST_STORED) ? int'(LIST_CURRENT) : int'(q.lst);
		case (q.op)
			OP_BYTE: begin
				if (q.start) begin
					list_fill[l] = 5'd0;
					low_next     = 1'b0;
				end
				if (!low_next) begin
					held_byte = q.data;
					low_next  = 1'b1;
				end else begin
					code     = {held_byte, q.data};
					low_next = 1'b0;
					// skip zero codes, drop codes past a full list
					if (code != 16'h0000 && list_fill[l] < MaxEntries) begin
						list_code[l][list_fill[l]]  = code;
						list_stamp[l][list_fill[l]] = q.ts;
						r = spell_code(KIND_STORED, code, list_fill[l][3:0], q.ts);
						list_fill[l] = list_fill[l] + 5'd1;
					end
				end
			end
			OP_CLEAR: begin
				list_fill[LIST_CURRENT] = 5'd0;
				list_fill[LIST_PENDING] = 5'd0;
			end
			OP_READ: begin
				if ({1'b0, q.idx} < list_fill[l]) begin
					r = spell_code(KIND_READ, list_code[l][q.idx], q.idx, list_stamp[l][q.idx]);
				end else begin
					r.kind = KIND_READ_ERR;
				end
			end
			default: ;
		endcase
		r.lcount = list_fill[l];
		r.tcount = 6'(list_fill[0]) + 6'(list_fill[1]) + 6'(list_fill[2]);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	// Queue one request with a random timestamp, extremes now and then
	task automatic queue_request(input logic [1:0] op, input logic [1:0] lst,
			input logic start, input logic [7:0] data, input logic [3:0] idx,
			inout int counted);
		dtc_row_t row;
		int       pick;
		pick      = $urandom_range(99);
		row       = '0;
		row.req   = '{op, lst, start, data, idx, $urandom};
		if (pick < 3) begin
			row.req.ts = '0;
		end else if (pick < 6) begin
			row.req.ts = '1;
		end
		request_queue.push_back(row);
		if (op != OP_NOP) begin
			counted++;
		end
	endtask

	// Source, sink and checking, all on the rising edge
	always @(posedge clk) begin
		dtc_res_t got;
		dtc_res_t want;
		logic     quiet;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			cycle_count++;
			quiet = (cycle_count >= QuietFrom) && (cycle_count < QuietTo);

			// check a result transaction against the oldest expectation
			if (m_tvalid && m_tready) begin
				result_count++;
				got = {m_tuser, m_tdata[15:0], m_tdata[17:16], m_tdata[25:18], m_tdata[33:26],
					m_tdata[41:34], m_tdata[49:42], m_tdata[57:50], m_tdata[61:58],
					m_tdata[93:62], m_tdata[98:94], m_tdata[104:99]};
				if (results_due.size() == 0) begin
					$display("%0t: result with none expected, actual %h", $time, got);
					error_count++;
				end else begin
					want = results_due.pop_front();
					kind_seen[want.kind]++;
					check_field("result_kind", 32'(want.kind), 32'(got.kind));
					check_field("trouble_code", 32'(want.code), 32'(got.code));
					check_field("system_class", 32'(want.cls), 32'(got.cls));
					check_field("system_letter", 32'(want.letter), 32'(got.letter));
					check_field("subsystem_digit", 32'(want.digit), 32'(got.digit));
					check_field("hex_char_high", 32'(want.hex_hi), 32'(got.hex_hi));
					check_field("hex_char_mid", 32'(want.hex_mid), 32'(got.hex_mid));
					check_field("hex_char_low", 32'(want.hex_lo), 32'(got.hex_lo));
					check_field("slot_index", 32'(want.slot), 32'(got.slot));
					check_field("entry_time", want.stamp, got.stamp);
					check_field("list_count", 32'(want.lcount), 32'(got.lcount));
					check_field("total_count", 32'(want.tcount), 32'(got.tcount));
				end
			end

			// predict the accepted transaction; typed rows override the model
			if (s_tvalid && s_tready) begin
				want = step_code_lists(in_flight.req);
				results_due.push_back(in_flight.typed ? in_flight.res : want);
				sent_count++;
			end

			// present the next transaction or idle
			if (!s_tvalid || s_tready) begin
				if (request_queue.size() != 0 && (quiet || $urandom_range(99) >= IdlePercent)) begin
					in_flight = request_queue.pop_front();
					s_tvalid  <= 1'b1;
					s_tdata   <= {4'h0, in_flight.req.ts, in_flight.req.idx, in_flight.req.data};
					s_tuser   <= {in_flight.req.start, in_flight.req.lst, in_flight.req.op};
				end else begin
					s_tvalid <= 1'b0;
				end
			end

			m_tready <= quiet || ($urandom_range(99) >= IdlePercent);
		end
	end

	initial begin
		int         counted;
		int         pick;
		int         n_codes;
		int         burst;
		logic [1:0] lst;
		logic       opened;
		logic       zero_code;
		counted = 0;

		foreach (DIRECTED[i]) begin
			request_queue.push_back(DIRECTED[i]);
		end

		// Random part: mostly well-formed responses, then reads, clears and noise
		while (counted < RandomItems) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				lst     = 2'($urandom_range(3));
				n_codes = ($urandom_range(3) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 8);
				opened  = ($urandom_range(3) != 0);
				for (int k = 0; k < n_codes; k++) begin
					zero_code = ($urandom_range(11) == 0);
					queue_request(OP_BYTE, lst, opened && k == 0,
						zero_code ? 8'h00 : 8'($urandom), 4'($urandom), counted);
					// switch list mid-pair now and then
					if ($urandom_range(19) == 0) begin
						lst = 2'($urandom_range(3));
					end
					queue_request(OP_BYTE, lst, 1'b0,
						zero_code ? 8'h00 : 8'($urandom), 4'($urandom), counted);
				end
				if ($urandom_range(9) == 0) begin
					queue_request(OP_BYTE, lst, n_codes == 0 && opened, 8'($urandom),
						4'($urandom), counted);
				end
			end else if (pick < 80) begin
				burst = $urandom_range(1, 6);
				repeat (burst) begin
					queue_request(OP_READ, 2'($urandom_range(3)), 1'($urandom), 8'($urandom),
						$urandom_range(1) ? 4'($urandom) : 4'($urandom_range(3)), counted);
				end
			end else if (pick < 86) begin
				queue_request(OP_CLEAR, 2'($urandom_range(3)), 1'($urandom), 8'($urandom),
					4'($urandom), counted);
			end else if (pick < 92) begin
				queue_request(OP_NOP, 2'($urandom_range(3)), 1'($urandom), 8'($urandom),
					4'($urandom), counted);
			end else begin
				queue_request(OP_BYTE, 2'($urandom_range(3)), 1'($urandom), 8'($urandom),
					4'($urandom), counted);
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every request to go in and every result to come out
		while (cycle_count < CycleLimit &&
				!(request_queue.size() == 0 && !s_tvalid && results_due.size() == 0)) begin
			@(negedge clk);
		end

		if (cycle_count >= CycleLimit) begin
			$display("%0t: timeout with %0d requests and %0d results outstanding", $time,
				request_queue.size(), results_due.size());
			$display("status: fail");
			$finish;
		end else begin
			repeat (DrainCycles) @(negedge clk);
			if (results_due.size() != 0) begin
				$display("%0t: %0d expected results never arrived", $time, results_due.size());
				error_count++;
			end
			$display("Sent %0d transactions, checked %0d results in %0d cycles.", sent_count,
				result_count, cycle_count);
			$display("Results seen: %0d idle, %0d stored, %0d read, %0d read errors.",
				kind_seen[KIND_NONE], kind_seen[KIND_STORED], kind_seen[KIND_READ],
				kind_seen[KIND_READ_ERR]);
			if (error_count == 0) begin
				$display("status: pass");
			end else begin
				$display("status: fail");
			end
			$finish;
		end
	end

endmodule

// ===== sim.f =====
src/drle_pkg.sv
src/dtc_response_list_engine.sv
tb/sv/dtc_response_list_engine_tb.sv
